// ----- hdl/double_ended_queue_defines.svh -----
// Assertion macros shared by the queue modules.
// Each macro expects the signals clk and rst_n in the module that uses it.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The property must hold at every clock edge out of reset.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define DQ_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/deque_pkg.sv -----
package deque_pkg;

    // Ring capacity in words.
    localparam int DEPTH = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CMD_W = 3;
    localparam int OCC_W = 9;

    localparam int SCALE_SHIFT = 10;
    localparam logic signed [WORD_W-1:0] SCALE_LIMIT = 32'sd2097151;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_SCALE      = 3'd5
    } cmd_t;

    // What the result register is loaded with.
    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_POP,
        RES_EMPTY,
        RES_FULL
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_front;
        logic write_back;
        logic read_front;
        logic read_back;
        logic clear;
        logic walk_start;
        logic walk_run;
        logic res_load;
        res_t res_kind;
    } dq_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_done;
    } dq_stat_t;

    // (base + off) modulo DEPTH, with base below DEPTH and off at most DEPTH.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    // Multiply by 1024, saturating large positive words; negatives wrap.
    function automatic logic [WORD_W-1:0] scale_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] res;
        if ($signed(w) > SCALE_LIMIT)
        begin
            res = WORD_MAX;
        end
        else
        begin
            res = w << SCALE_SHIFT;
        end
        return res;
    endfunction

endpackage

// ----- hdl/deque_ram.sv -----
module deque_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/deque_dp.sv -----
`include "double_ended_queue_defines.svh"

module deque_dp
    import deque_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dq_ctrl_t          ctrl,
    input  logic [WORD_W-1:0] value,
    output dq_stat_t          stat,
    output logic [WORD_W-1:0] popped_word,
    output logic              was_empty,
    output logic              was_full,
    output logic [OCC_W-1:0]  occupancy
);

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  walk_idx_reg, walk_idx_next;
    logic              walk_pend_reg, walk_pend_next;
    logic [ADDR_W-1:0] walk_addr_reg;
    logic [WORD_W-1:0] popped_reg;
    logic              empty_flag_reg, full_flag_reg;
    logic [OCC_W-1:0]  occ_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr, front_dec;
    logic [WORD_W-1:0] wr_data, rd_data;
    logic              walk_more, walk_issue;

    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign walk_more = walk_idx_reg < count_reg;
    assign walk_issue = ctrl.walk_run && walk_more;

    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg >= CNT_W'(DEPTH));
    assign stat.walk_done = !walk_more && !walk_pend_reg;

    // Write port: pushes, or the write-back half of the scale walk.
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = front_reg;
        wr_data = value;
        if (ctrl.write_front)
        begin
            wr_en = 1'b1;
            wr_addr = front_dec;
        end
        else if (ctrl.write_back)
        begin
            wr_en = 1'b1;
            wr_addr = ring_add(front_reg, count_reg);
        end
        else if (walk_pend_reg)
        begin
            wr_en = 1'b1;
            wr_addr = walk_addr_reg;
            wr_data = scale_word(rd_data);
        end
    end

    always_comb
    begin
        if (ctrl.read_back)
        begin
            rd_addr = ring_add(front_reg, count_reg - 1'b1);
        end
        else if (ctrl.walk_run)
        begin
            rd_addr = ring_add(front_reg, walk_idx_reg);
        end
        else
        begin
            rd_addr = front_reg;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            front_next = '0;
            count_next = '0;
        end
        else if (ctrl.write_front || ctrl.write_back)
        begin
            count_next = count_reg + 1'b1;
            if (ctrl.write_front)
            begin
                front_next = front_dec;
            end
        end
        else if (ctrl.read_front || ctrl.read_back)
        begin
            count_next = count_reg - 1'b1;
            if (ctrl.read_front)
            begin
                front_next = ring_add(front_reg, CNT_W'(1));
            end
        end
    end

    always_comb
    begin
        walk_idx_next = walk_idx_reg;
        walk_pend_next = 1'b0;
        if (ctrl.walk_start)
        begin
            walk_idx_next = '0;
        end
        else if (walk_issue)
        begin
            walk_idx_next = walk_idx_reg + 1'b1;
            walk_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            walk_idx_reg <= '0;
            walk_pend_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            walk_idx_reg <= walk_idx_next;
            walk_pend_reg <= walk_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_issue)
        begin
            walk_addr_reg <= rd_addr;
        end
        if (ctrl.res_load)
        begin
            occ_reg <= OCC_W'(count_next);
            empty_flag_reg <= (ctrl.res_kind == RES_EMPTY);
            full_flag_reg <= (ctrl.res_kind == RES_FULL);
            case (ctrl.res_kind)
                RES_POP:   popped_reg <= rd_data;
                RES_EMPTY: popped_reg <= EMPTY_WORD;
                default:   popped_reg <= '0;
            endcase
        end
    end

    deque_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign popped_word = popped_reg;
    assign was_empty = empty_flag_reg;
    assign was_full = full_flag_reg;
    assign occupancy = occ_reg;

    `DQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "count exceeds capacity")
    `DQ_ASSERT_ALWAYS(a_walk_no_push, !(walk_pend_reg && (ctrl.write_front || ctrl.write_back)), "push collides with scale write-back")

endmodule

// ----- hdl/deque_ctrl.sv -----
`include "double_ended_queue_defines.svh"

module deque_ctrl
    import deque_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dq_ctrl_t         ctrl,
    input  dq_stat_t         stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SCALE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;
    logic   pop_taken;
    logic   pop_waiting;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        ctrl = '0;
        ctrl.res_kind = RES_PLAIN;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            ctrl.res_load = 1'b1;
                            if (stat.full)
                            begin
                                ctrl.res_kind = RES_FULL;
                            end
                            else
                            begin
                                ctrl.write_front = (in_cmd == CMD_PUSH_FRONT);
                                ctrl.write_back = (in_cmd == CMD_PUSH_BACK);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                ctrl.res_load = 1'b1;
                                ctrl.res_kind = RES_EMPTY;
                            end
                            else
                            begin
                                ctrl.read_front = (in_cmd == CMD_POP_FRONT);
                                ctrl.read_back = (in_cmd == CMD_POP_BACK);
                                state_next = ST_POP_WAIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctrl.clear = 1'b1;
                            ctrl.res_load = 1'b1;
                        end
                        CMD_SCALE:
                        begin
                            ctrl.walk_start = 1'b1;
                            state_next = ST_SCALE;
                        end
                        default:
                        begin
                            ctrl.res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_WAIT:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_kind = RES_POP;
                state_next = ST_IDLE;
            end
            ST_SCALE:
            begin
                ctrl.walk_run = 1'b1;
                if (stat.walk_done)
                begin
                    ctrl.res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A pop that finds data must wait in ST_POP_WAIT for the memory read.
    assign pop_taken = accept && !stat.empty
                       && (in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_BACK);
    assign pop_waiting = (state_reg == ST_POP_WAIT) && !out_valid_reg;

    `DQ_ASSERT_ALWAYS(a_load_free, !ctrl.res_load || out_free, "result overwrites a waiting item")
    `DQ_ASSERT_NEXT(a_pop_wait, pop_taken, pop_waiting, "pop did not wait for memory data")

endmodule

// ----- hdl/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit words held as a ring in a
// 256-entry memory with one write port and one registered read port. Each
// input item carries a command (push front, push back, pop front, pop back,
// clear, scale all) and a value, and produces exactly one result item with
// the popped word, the empty and full flags, and the occupancy after the
// command. Push, clear, a pop on an empty queue and unused command codes
// load the result register in the cycle they are accepted; a pop that finds
// data waits in ST_POP_WAIT because the memory read is registered; scale all
// walks the stored entries in ST_SCALE, reading one entry and writing back
// one entry per cycle through the single memory port pair. The block works
// on one item at a time and accepts a new item in the cycle its previous
// result is taken, so pushes run at one item per cycle while the output is
// drained. A pop on an empty queue returns -1 with the empty flag set, and
// a push on a full queue is dropped with the full flag set. Scale all
// multiplies each word by 1024, saturating words above 2097151 to
// 2147483647 and letting negative words wrap. The memory has no reset and
// needs no clearing pass: only live entries are ever read.
module double_ended_queue
    import deque_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [7:0]  s_axis_tuser,  // [2:0] command, upper bits unused
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [31:0] popped_word, [40:32] occupancy, rest zero
    output logic [1:0]  m_axis_tuser   // [0] was_empty, [1] was_full
);

    dq_ctrl_t          ctrl;
    dq_stat_t          stat;
    logic [WORD_W-1:0] popped_word;
    logic              was_empty, was_full;
    logic [OCC_W-1:0]  occupancy;

    // The controller sequences pops and the scale walk; the datapath holds
    // the ring pointers, the memory and the result register.
    deque_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser[CMD_W-1:0]),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    deque_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .value      (s_axis_tdata[WORD_W-1:0]),
        .stat       (stat),
        .popped_word(popped_word),
        .was_empty  (was_empty),
        .was_full   (was_full),
        .occupancy  (occupancy)
    );

    // Pack the result item; the top seven bits pad tdata to whole bytes.
    assign m_axis_tdata = {7'b0, occupancy, popped_word};
    assign m_axis_tuser = {was_full, was_empty};

endmodule
